FILE: src/wphac_pkg.sv
// wphac_pkg: shared constants, field widths and controller/datapath interface types
// for the watchpoint hit address counter; no dependencies
package wphac_pkg;

  // table geometry
  localparam int ENTRIES    = 1024;
  localparam int ADDR_BITS  = 64;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W     = $clog2(ENTRIES + 1);

  // port field widths
  localparam int CMD_W      = 2;
  localparam int HADDR_W    = 64;
  localparam int RIDX_W     = 10;
  localparam int SLOT_W     = 10;
  localparam int ECOUNT_W   = 32;
  localparam int FILL_OUT_W = 11;
  localparam int TOTAL_W    = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // finishing operation issued by the controller
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_HIT    = 3'd1,
    OP_MISS   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_IGNORE = 3'd5
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic rd_req;
    op_t  op;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic exhausted;
  } sts_t;

endpackage

FILE: src/wphac_ram.sv
// wphac_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module wphac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/wphac_ctrl.sv
// wphac_ctrl: command sequencer for the hit table (accept, scan, read, finish)
// depends on wphac_pkg
module wphac_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [wphac_pkg::CMD_W-1:0]    in_cmd,
  input  logic                           in_status_nonzero,
  input  wphac_pkg::sts_t                sts,
  output wphac_pkg::ctl_t                ctl
);
  import wphac_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_RDREQ  = 6'b000100,
    S_RDRSP  = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_IGNORE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    ctl.load   = 1'b0;
    ctl.scan   = 1'b0;
    ctl.rd_req = 1'b0;
    ctl.op     = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (in_cmd)
            CMD_RECORD: state_nxt = in_status_nonzero ? S_SCAN : S_IGNORE;
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_READ:   state_nxt = S_RDREQ;
            default:    state_nxt = S_IGNORE;
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.match) begin
          ctl.op    = OP_HIT;
          state_nxt = S_IDLE;
        end else if (sts.exhausted) begin
          ctl.op    = OP_MISS;
          state_nxt = S_IDLE;
        end
      end
      S_RDREQ: begin
        ctl.rd_req = 1'b1;
        state_nxt  = S_RDRSP;
      end
      S_RDRSP: begin
        ctl.op    = OP_READ;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        ctl.op    = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      S_IGNORE: begin
        ctl.op    = OP_IGNORE;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: src/wphac_dpath.sv
// wphac_dpath: table memories, scan pointer, fill level, flags and result registers
// depends on wphac_pkg and wphac_ram
module wphac_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wphac_pkg::ctl_t                   ctl,
  output wphac_pkg::sts_t                   sts,
  input  logic [wphac_pkg::HADDR_W-1:0]     in_hit_address,
  input  logic [wphac_pkg::RIDX_W-1:0]      in_read_index,
  output logic                              out_valid,
  output logic                              out_handled,
  output logic                              out_found_existing,
  output logic                              out_inserted,
  output logic                              out_overflow,
  output logic [wphac_pkg::SLOT_W-1:0]      out_slot_index,
  output logic                              out_entry_valid,
  output logic [wphac_pkg::HADDR_W-1:0]     out_entry_address,
  output logic [wphac_pkg::ECOUNT_W-1:0]    out_entry_count,
  output logic [wphac_pkg::FILL_OUT_W-1:0]  out_fill_level,
  output logic [wphac_pkg::TOTAL_W-1:0]     out_total_hits
);
  import wphac_pkg::*;

  // table state
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [TOTAL_W-1:0]    total_r, total_nxt;

  // latched transaction payload
  logic [ADDR_BITS-1:0]  addr_r, addr_nxt;
  logic [RIDX_W-1:0]     ridx_r, ridx_nxt;

  // scan pointer and compare stage
  logic [FILL_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                  cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0]      cmp_idx_r, cmp_idx_nxt;

  // result registers
  logic                  valid_r, valid_nxt;
  logic                  handled_r, handled_nxt;
  logic                  found_r, found_nxt;
  logic                  ins_r, ins_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  evalid_r, evalid_nxt;
  logic [HADDR_W-1:0]    eaddr_r, eaddr_nxt;
  logic [ECOUNT_W-1:0]   ecount_r, ecount_nxt;

  // memory ports
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_idx;
  logic                  addr_we;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [ADDR_BITS-1:0]  ram_addr_q;
  logic [COUNT_BITS-1:0] ram_cnt_q;

  logic                  issue;
  logic                  full;
  logic                  rd_in_range;
  logic [COUNT_BITS-1:0] count_inc;
  logic [TOTAL_W-1:0]    total_inc;

  // address and count tables
  wphac_ram #(.WIDTH(ADDR_BITS), .DEPTH(ENTRIES)) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (wr_idx),
    .wdata (addr_r),
    .raddr (rd_addr),
    .rdata (ram_addr_q)
  );

  wphac_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_idx),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (ram_cnt_q)
  );

  // read address: scan pointer, or the requested index for a read
  assign rd_addr = ctl.rd_req ? IDX_W'(ridx_r) : rd_idx_r[IDX_W-1:0];
  assign issue   = ctl.scan && (rd_idx_r < fill_r);

  // scan status
  assign sts.match     = cmp_valid_r && (ram_addr_q == addr_r);
  assign sts.exhausted = !cmp_valid_r && (rd_idx_r >= fill_r);

  // saturating increments and table checks
  assign full        = (fill_r == FILL_W'(ENTRIES));
  assign count_inc   = (ram_cnt_q == '1) ? ram_cnt_q : ram_cnt_q + COUNT_BITS'(1);
  assign total_inc   = (total_r == '1) ? total_r : total_r + TOTAL_W'(1);
  assign rd_in_range = (32'(ridx_r) < 32'(fill_r)) && (32'(ridx_r) < 32'(ENTRIES));

  // table writes: count bump on a hit, new entry on a miss with room
  assign addr_we   = (ctl.op == OP_MISS) && !full;
  assign cnt_we    = (ctl.op == OP_HIT) || addr_we;
  assign wr_idx    = (ctl.op == OP_HIT) ? cmp_idx_r : fill_r[IDX_W-1:0];
  assign cnt_wdata = (ctl.op == OP_HIT) ? count_inc : COUNT_BITS'(1);

  // next state and result values
  always_comb begin
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    addr_nxt      = addr_r;
    ridx_nxt      = ridx_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    cmp_idx_nxt   = cmp_idx_r;
    valid_nxt     = (ctl.op != OP_NONE);
    handled_nxt   = handled_r;
    found_nxt     = found_r;
    ins_nxt       = ins_r;
    slot_nxt      = slot_r;
    evalid_nxt    = evalid_r;
    eaddr_nxt     = eaddr_r;
    ecount_nxt    = ecount_r;

    // capture the transaction and rewind the scan
    if (ctl.load) begin
      addr_nxt      = ADDR_BITS'(in_hit_address);
      ridx_nxt      = in_read_index;
      rd_idx_nxt    = '0;
      cmp_valid_nxt = 1'b0;
    end

    // one entry read per cycle, compared in the following cycle
    if (ctl.scan) begin
      rd_idx_nxt    = rd_idx_r + FILL_W'(issue);
      cmp_valid_nxt = issue;
      cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
    end

    if (ctl.op != OP_NONE) begin
      handled_nxt = 1'b0;
      found_nxt   = 1'b0;
      ins_nxt     = 1'b0;
      slot_nxt    = '0;
      evalid_nxt  = 1'b0;
      eaddr_nxt   = '0;
      ecount_nxt  = '0;
    end

    case (ctl.op)
      OP_HIT: begin
        handled_nxt = 1'b1;
        found_nxt   = 1'b1;
        slot_nxt    = SLOT_W'(cmp_idx_r);
        total_nxt   = total_inc;
      end
      OP_MISS: begin
        handled_nxt = 1'b1;
        total_nxt   = total_inc;
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          ins_nxt  = 1'b1;
          slot_nxt = SLOT_W'(fill_r);
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
      OP_READ: begin
        slot_nxt = SLOT_W'(ridx_r);
        if (rd_in_range) begin
          evalid_nxt = 1'b1;
          eaddr_nxt  = HADDR_W'(ram_addr_q);
          ecount_nxt = ECOUNT_W'(ram_cnt_q);
        end
      end
      OP_CLEAR: begin
        fill_nxt  = '0;
        ovf_nxt   = 1'b0;
        total_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      cmp_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    ridx_r    <= ridx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    handled_r <= handled_nxt;
    found_r   <= found_nxt;
    ins_r     <= ins_nxt;
    slot_r    <= slot_nxt;
    evalid_r  <= evalid_nxt;
    eaddr_r   <= eaddr_nxt;
    ecount_r  <= ecount_nxt;
  end

  // result ports; table state is stable until the next finishing op
  assign out_valid          = valid_r;
  assign out_handled        = handled_r;
  assign out_found_existing = found_r;
  assign out_inserted       = ins_r;
  assign out_overflow       = ovf_r;
  assign out_slot_index     = slot_r;
  assign out_entry_valid    = evalid_r;
  assign out_entry_address  = eaddr_r;
  assign out_entry_count    = ecount_r;
  assign out_fill_level     = FILL_OUT_W'(fill_r);
  assign out_total_hits     = total_r;

  // fill level never passes the table size
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= ENTRIES)
    else $error("fill level beyond table size");

  // a result strobe lasts one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held");

  // an insert grows the table by exactly one
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ins_r) |-> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("insert without fill growth");

  // a match and an insert never come together, and inserts never follow an overflow
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ins_r) |-> (!found_r && !ovf_r))
    else $error("insert with match or overflow");

endmodule

FILE: src/watchpoint_hit_address_counter.sv
// watchpoint_hit_address_counter: top level, controller plus datapath
// depends on wphac_pkg, wphac_ctrl, wphac_dpath (and wphac_ram below it)
//
//  channel   handshake                 payload
//  input     start / busy              in_cmd, in_status_nonzero, in_hit_address,
//                                      in_read_index
//  result    out_valid (1-cycle)       out_handled ... out_total_hits
//
// a transaction is taken when start is high and busy low; its result shows for
// one cycle on out_valid, the first cycle with busy low again.
// record: busy while the scan reads the address table one entry per cycle, until
// a match or the last filled entry; read: busy for one registered table read.
// clear and ignored commands pass only through S_CLEAR or S_IGNORE.
// reset (synchronous, rst_n low) empties the table and clears flags and total;
// the receiver cannot stall the result.
module watchpoint_hit_address_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [wphac_pkg::CMD_W-1:0]       in_cmd,
  input  logic                              in_status_nonzero,
  input  logic [wphac_pkg::HADDR_W-1:0]     in_hit_address,
  input  logic [wphac_pkg::RIDX_W-1:0]      in_read_index,
  output logic                              out_valid,
  output logic                              out_handled,
  output logic                              out_found_existing,
  output logic                              out_inserted,
  output logic                              out_overflow,
  output logic [wphac_pkg::SLOT_W-1:0]      out_slot_index,
  output logic                              out_entry_valid,
  output logic [wphac_pkg::HADDR_W-1:0]     out_entry_address,
  output logic [wphac_pkg::ECOUNT_W-1:0]    out_entry_count,
  output logic [wphac_pkg::FILL_OUT_W-1:0]  out_fill_level,
  output logic [wphac_pkg::TOTAL_W-1:0]     out_total_hits
);
  import wphac_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencer
  wphac_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_status_nonzero (in_status_nonzero),
    .sts               (sts),
    .ctl               (ctl)
  );

  // table and result datapath
  wphac_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_hit_address     (in_hit_address),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_handled        (out_handled),
    .out_found_existing (out_found_existing),
    .out_inserted       (out_inserted),
    .out_overflow       (out_overflow),
    .out_slot_index     (out_slot_index),
    .out_entry_valid    (out_entry_valid),
    .out_entry_address  (out_entry_address),
    .out_entry_count    (out_entry_count),
    .out_fill_level     (out_fill_level),
    .out_total_hits     (out_total_hits)
  );

endmodule
